### hdl/me_pkg.sv
// ----------------------------------------------------------------------------
// me_pkg: shared types and helpers for the modular exponentiation pipeline
// Field widths, the in-flight item record and the restoring reduction step.
// ----------------------------------------------------------------------------
package me_pkg;

  localparam int MOD_W   = 31;   // modulus and residue width
  localparam int FIELD_W = 63;   // base and exponent width
  localparam int PROD_W  = 64;   // product or base, padded to whole digit groups
  localparam int STEPS   = 4;    // restoring steps per reduction stage
  localparam int RED_STAGES = PROD_W / STEPS;
  localparam logic [MOD_W-1:0] MODULUS_RESET = 31'd1000000007;

  typedef struct packed {
    logic               valid;
    logic               zexp;    // whole exponent field is zero
    logic               zbase;   // whole base field is zero
    logic [FIELD_W-1:0] exponent;
    logic [MOD_W-1:0]   acc;
    logic [MOD_W-1:0]   sq;
  } me_item_t;

  // Shifts STEPS more product bits into a partial remainder, keeping it below m.
  function automatic logic [MOD_W-1:0] red_step(input logic [MOD_W-1:0] r,
                                                input logic [STEPS-1:0] bits,
                                                input logic [MOD_W-1:0] m);
    logic [MOD_W:0]   t;
    logic [MOD_W-1:0] x;
    x = r;
    for (int i = STEPS - 1; i >= 0; i--) begin
      t = {x, bits[i]};
      if (t >= {1'b0, m}) begin
        t = t - {1'b0, m};
      end
      x = t[MOD_W-1:0];
    end
    return x;
  endfunction

endpackage

### hdl/me_prered.sv
// ----------------------------------------------------------------------------
// me_prered: base reduction front end
// Reduces the 63-bit base modulo the modulus over a row of restoring stages.
// ----------------------------------------------------------------------------
module me_prered import me_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                ce,
  input  logic [MOD_W-1:0]    m,
  input  logic                in_valid,
  input  logic [FIELD_W-1:0]  base,
  input  logic [FIELD_W-1:0]  exponent,
  output me_item_t            item_out
);

  me_item_t          it_in;
  me_item_t          it [1:RED_STAGES];
  logic [PROD_W-1:0] pr [1:RED_STAGES];
  logic [MOD_W-1:0]  r  [1:RED_STAGES];

  always_comb begin
    it_in          = '0;
    it_in.valid    = in_valid;
    it_in.zexp     = (exponent == '0);
    it_in.zbase    = (base == '0);
    it_in.exponent = exponent;
  end

  for (genvar k = 1; k <= RED_STAGES; k++) begin : g_stage
    me_item_t          it_prev;
    logic [PROD_W-1:0] pr_prev;
    logic [MOD_W-1:0]  r_prev;

    if (k == 1) begin : g_head
      assign it_prev = it_in;
      assign pr_prev = {1'b0, base};
      assign r_prev  = '0;
    end else begin : g_tail
      assign it_prev = it[k-1];
      assign pr_prev = pr[k-1];
      assign r_prev  = r[k-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        it[k].valid <= 1'b0;
      end else if (ce) begin
        it[k].valid <= it_prev.valid;
      end
    end
    always_ff @(posedge clk) begin
      if (ce) begin
        it[k].zexp     <= it_prev.zexp;
        it[k].zbase    <= it_prev.zbase;
        it[k].exponent <= it_prev.exponent;
        it[k].acc      <= it_prev.acc;
        it[k].sq       <= it_prev.sq;
        pr[k]          <= pr_prev << STEPS;
        r[k]           <= red_step(r_prev, pr_prev[PROD_W-1 -: STEPS], m);
      end
    end
  end

  always_comb begin
    item_out     = it[RED_STAGES];
    item_out.sq  = r[RED_STAGES];
    item_out.acc = (m == MOD_W'(1)) ? '0 : MOD_W'(1);
  end

endmodule

### hdl/me_cell.sv
// ----------------------------------------------------------------------------
// me_cell: one square-and-multiply cell
// Handles one exponent bit: forms acc*sq and sq*sq, then reduces both.
// ----------------------------------------------------------------------------
module me_cell import me_pkg::*; #(
  parameter int BIT_IDX = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             ce,
  input  logic [MOD_W-1:0] m,
  input  me_item_t         item_in,
  output me_item_t         item_out
);

  me_item_t          it [0:RED_STAGES];
  logic [PROD_W-1:0] pa [0:RED_STAGES];
  logic [PROD_W-1:0] ps [0:RED_STAGES];
  logic [MOD_W-1:0]  ra [0:RED_STAGES];
  logic [MOD_W-1:0]  rs [0:RED_STAGES];
  logic [2*MOD_W-1:0] prod_a;
  logic [2*MOD_W-1:0] prod_s;
  logic              ebit;

  assign prod_a = item_in.acc * item_in.sq;
  assign prod_s = item_in.sq * item_in.sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      it[0].valid <= 1'b0;
    end else if (ce) begin
      it[0].valid <= item_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      it[0].zexp     <= item_in.zexp;
      it[0].zbase    <= item_in.zbase;
      it[0].exponent <= item_in.exponent;
      it[0].acc      <= item_in.acc;
      it[0].sq       <= item_in.sq;
      pa[0]          <= {{(PROD_W-2*MOD_W){1'b0}}, prod_a};
      ps[0]          <= {{(PROD_W-2*MOD_W){1'b0}}, prod_s};
      ra[0]          <= '0;
      rs[0]          <= '0;
    end
  end

  for (genvar k = 1; k <= RED_STAGES; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        it[k].valid <= 1'b0;
      end else if (ce) begin
        it[k].valid <= it[k-1].valid;
      end
    end
    always_ff @(posedge clk) begin
      if (ce) begin
        it[k].zexp     <= it[k-1].zexp;
        it[k].zbase    <= it[k-1].zbase;
        it[k].exponent <= it[k-1].exponent;
        it[k].acc      <= it[k-1].acc;
        it[k].sq       <= it[k-1].sq;
        pa[k]          <= pa[k-1] << STEPS;
        ps[k]          <= ps[k-1] << STEPS;
        ra[k]          <= red_step(ra[k-1], pa[k-1][PROD_W-1 -: STEPS], m);
        rs[k]          <= red_step(rs[k-1], ps[k-1][PROD_W-1 -: STEPS], m);
      end
    end
  end

  // Bit positions past the field width are always zero.
  if (BIT_IDX < FIELD_W) begin : g_bit
    assign ebit = it[RED_STAGES].exponent[BIT_IDX % FIELD_W];
  end else begin : g_nobit
    assign ebit = 1'b0;
  end

  always_comb begin
    item_out     = it[RED_STAGES];
    item_out.sq  = rs[RED_STAGES];
    item_out.acc = ebit ? ra[RED_STAGES] : it[RED_STAGES].acc;
  end

endmodule

### hdl/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation: pipelined base^exponent mod modulus
// Base reduction front end, a chain of square-and-multiply cells, output queue.
//
//   Channel   Dir  Handshake                  Content
//   s_axis    in   s_tvalid / s_tready        base, exponent
//   m_axis    out  m_tvalid / m_tready        power_result
//   apb       in   psel/penable/pwrite/pready modulus at address 0
//
// One transaction is accepted per cycle while the output queue has room. The
// base passes 16 reduction stages, then per exponent bit one multiply stage
// and 16 four-bit restoring reduction stages, then the output queue register.
// Reset clears all stage valid bits and loads the modulus with 1000000007.
// The pipeline advances as a whole while the two-entry output queue has room,
// so inputs keep flowing while one result waits.
// ----------------------------------------------------------------------------
module modular_exponentiation import me_pkg::*; #(
  parameter int EXPONENT_BITS = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // [62:0] base, [125:63] exponent, rest zero
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [31:0]  m_tdata,   // [30:0] power_result, bit 31 zero
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [MOD_W-1:0] modulus;
  logic [MOD_W-1:0] m_eff;
  logic             ce;
  me_item_t         chain [0:EXPONENT_BITS];
  me_item_t         last;
  logic [MOD_W-1:0] result;
  logic [MOD_W-1:0] q_mem [0:1];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;
  logic             pop;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {1'b0, modulus} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MODULUS_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      modulus <= pwdata[MOD_W-1:0];
    end
  end

  assign m_eff = (modulus == '0) ? MOD_W'(1) : modulus;

  assign ce       = (count != 2'd2);
  assign s_tready = ce;

  me_prered u_prered (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .m        (m_eff),
    .in_valid (s_tvalid),
    .base     (s_tdata[62:0]),
    .exponent (s_tdata[125:63]),
    .item_out (chain[0])
  );

  for (genvar i = 0; i < EXPONENT_BITS; i++) begin : g_cell
    me_cell #(.BIT_IDX(i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ce       (ce),
      .m        (m_eff),
      .item_in  (chain[i]),
      .item_out (chain[i+1])
    );
  end

  assign last   = chain[EXPONENT_BITS];
  assign result = last.zexp ? MOD_W'(1) : (last.zbase ? '0 : last.acc);

  // Output queue.
  assign push     = ce && last.valid;
  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (count != 2'd0);
  assign m_tdata  = {1'b0, q_mem[rd_ptr]};

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("output queue count out of range");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    $past(push) && !$past(pop) && !$past(rst) |-> count == $past(count) + 2'd1)
    else $error("output queue count did not follow a push");

  a_result_range: assert property (@(posedge clk) disable iff (rst)
    last.valid |-> (result < m_eff) || (result == MOD_W'(1)))
    else $error("result not reduced below the modulus");

endmodule

### tb/sv/modular_exponentiation_test.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_test: self-checking bench for modular exponentiation
// Streams base/exponent pairs through the pipeline under several moduli,
// predicts each power residue in the bench and compares results in order.
// ----------------------------------------------------------------------------
module modular_exponentiation_test;
  import me_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 16 + 17 * 64 + 1;

  typedef struct packed {
    logic [FIELD_W-1:0] base;
    logic [FIELD_W-1:0] exponent;
  } power_req_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;   // [62:0] base, [125:63] exponent, rest zero
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [31:0]  m_tdata;        // [30:0] power_result, bit 31 zero
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  modular_exponentiation DUT (.*);

  always #6 clk = ~clk;

  power_req_t       pending_reqs[$];
  logic [MOD_W-1:0] expected_powers[$];
  logic [MOD_W-1:0] cur_modulus = MODULUS_RESET;
  int errors = 0;
  int results_seen = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_cycles = 0;
  int stall_phase = 0;
  bit driver_pause = 1'b0;
  bit in_taken = 1'b0;

  function automatic logic [MOD_W-1:0] power_mod(input logic [FIELD_W-1:0] b,
                                                 input logic [FIELD_W-1:0] e,
                                                 input logic [MOD_W-1:0] m);
    logic [63:0] mm;
    logic [63:0] sq;
    logic [63:0] acc;
    mm = (m == 0) ? 64'd1 : {33'd0, m};
    if (e == 0) return MOD_W'(1);
    if (b == 0) return MOD_W'(0);
    sq = {1'b0, b} % mm;
    acc = 64'd1 % mm;
    for (int i = 0; i < FIELD_W; i++) begin
      if (e[i]) acc = (acc * sq) % mm;
      sq = (sq * sq) % mm;
    end
    return acc[MOD_W-1:0];
  endfunction

  // Input acceptance is taken at the rising edge where the handshake happens.
  always @(posedge clk) begin
    in_taken = 1'b0;
    if (!rst && s_tvalid && s_tready) begin
      expected_powers.push_back(power_mod(s_tdata[62:0], s_tdata[125:63],
                                          cur_modulus));
      void'(pending_reqs.pop_front());
      in_taken = 1'b1;
    end
  end

  // Driver: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    if (!rst) begin
      if (s_tvalid && !in_taken) begin
        // An offered transaction stays on the bus until it is accepted.
      end else begin
        if (gap_left > 0) gap_left--;
        if (!driver_pause && gap_left == 0 && pending_reqs.size() > 0) begin
          s_tvalid <= 1'b1;
          s_tdata <= {2'b00, pending_reqs[0].exponent, pending_reqs[0].base};
          if (burst_left > 0) begin
            burst_left--;
          end else if ($urandom_range(0, 3) != 0) begin
            burst_left = $urandom_range(0, 40);
            gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: a rotating stall pattern plus a long hold-off when requested.
  always @(negedge clk) begin
    if (!rst) begin
      stall_phase = (stall_phase + 1) % 23;
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_tready <= 1'b0;
      end else if (stall_phase < 8) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(0, 2) != 0);
      end
    end
  end

  // Monitor: compares every accepted result with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (expected_powers.size() == 0) begin
        $error("unexpected result power_result=%0d", m_tdata[30:0]);
        errors++;
      end else begin
        if (m_tdata[30:0] !== expected_powers[0]) begin
          $error("power_result expected %0d actual %0d", expected_powers[0],
                 m_tdata[30:0]);
          errors++;
        end
        if (m_tdata[31] !== 1'b0) begin
          $error("pad bit expected 0 actual %b", m_tdata[31]);
          errors++;
        end
        void'(expected_powers.pop_front());
      end
    end
  end

  task automatic write_modulus(input logic [MOD_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= {1'b0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    cur_modulus = value;
  endtask

  task automatic drain_all();
    wait (pending_reqs.size() == 0 && !s_tvalid && expected_powers.size() == 0);
    repeat (5) @(posedge clk);
  endtask

  function automatic logic [FIELD_W-1:0] rand63();
    logic [FIELD_W-1:0] v;
    v = FIELD_W'({$urandom, $urandom});
    case ($urandom_range(0, 5))
      0: v = v & 63'hFF;
      1: v = v & 63'hFFFF_FFFF;
      2: v = 63'h7FFF_FFFF_FFFF_FFFF - (v & 63'hF);
      default: ;
    endcase
    return v;
  endfunction

  task automatic queue_random(input int n);
    power_req_t r;
    for (int i = 0; i < n; i++) begin
      r.base = rand63();
      r.exponent = rand63();
      if ($urandom_range(0, 30) == 0) r.exponent = 0;
      if ($urandom_range(0, 30) == 0) r.base = 0;
      if ($urandom_range(0, 20) == 0) r.base = {32'd0, cur_modulus} * $urandom_range(0, 4);
      pending_reqs.push_back(r);
    end
  endtask

  logic [MOD_W-1:0] moduli[6];

  initial begin
    power_req_t r;
    moduli = '{31'd1, 31'h7FFF_FFFF, 31'd2, 31'd65537, 31'd3, 31'd0};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // Directed corners under the reset modulus.
    r.base = 0; r.exponent = 0; pending_reqs.push_back(r);
    r.base = 0; r.exponent = 5; pending_reqs.push_back(r);
    r.base = 7; r.exponent = 0; pending_reqs.push_back(r);
    r.base = '1; r.exponent = '1; pending_reqs.push_back(r);
    r.base = '1; r.exponent = 1; pending_reqs.push_back(r);
    r.base = 2; r.exponent = '1; pending_reqs.push_back(r);
    r.base = 31'd1000000007; r.exponent = 3; pending_reqs.push_back(r);
    r.base = 31'd1000000006; r.exponent = 2; pending_reqs.push_back(r);
    r.base = 63'h5555_5555_5555_5555; r.exponent = 63'h2AAA_AAAA_AAAA_AAAA;
    pending_reqs.push_back(r);
    r.base = 63'h4000_0000_0000_0000; r.exponent = 63'h4000_0000_0000_0000;
    pending_reqs.push_back(r);
    drain_all();
    // Long receiver hold-off: the first results fill the output queue and
    // freeze the pipeline, then the sender keeps offering into a full block.
    hold_cycles = 3 * LATENCY;
    queue_random(2);
    wait (hold_cycles < LATENCY);
    queue_random(148);
    drain_all();
    for (int p = 0; p < 6; p++) begin
      write_modulus(moduli[p]);
      r.base = 0; r.exponent = 0; pending_reqs.push_back(r);
      r.base = '1; r.exponent = '1; pending_reqs.push_back(r);
      r.base = 3; r.exponent = 0; pending_reqs.push_back(r);
      queue_random(p == 1 ? 300 : 90);
      if (p == 3) begin
        // Sender pauses until every result is back, then resumes.
        wait (pending_reqs.size() < 40);
        driver_pause = 1'b1;
        wait (expected_powers.size() == 0);
        driver_pause = 1'b0;
      end
      drain_all();
    end
    repeat (LATENCY + 20) @(posedge clk);
    $display("Checked %0d results across 7 modulus settings, including 0, 1, 2 and 2^31-1,",
             results_seen);
    $display("with zero operand corners, full-width fields and backpressure stalls.");
    if (errors == 0 && expected_powers.size() == 0) begin
      $display("modular_exponentiation: match");
    end else begin
      $display("modular_exponentiation: mismatch");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("modular_exponentiation: mismatch");
    $finish;
  end
endmodule
